[rtl/apt_pkg.sv]
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants of the aging peer table.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

   // command codes
   localparam logic [3:0] CMD_LEARN    = 4'd0;
   localparam logic [3:0] CMD_TOUCH    = 4'd1;
   localparam logic [3:0] CMD_EXPIRE   = 4'd2;
   localparam logic [3:0] CMD_MOVE     = 4'd3;
   localparam logic [3:0] CMD_SELECT   = 4'd4;
   localparam logic [3:0] CMD_CLEAR    = 4'd5;
   localparam logic [3:0] CMD_LOOKUP   = 4'd6;
   localparam logic [3:0] CMD_READ_SEL = 4'd7;
   localparam logic [3:0] CMD_READ_VIS = 4'd8;

   // register indexes
   localparam int         CSR_IDX_W   = 4;
   localparam logic [3:0] REG_LOCAL   = 4'd0;
   localparam logic [3:0] REG_TIMEOUT = 4'd1;

   localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

   // strengths at or below this keep the stored value
   localparam logic signed [7:0] STRENGTH_FLOOR = -8'sd127;

   // one table entry as stored in the memory
   typedef struct packed {
      logic [47:0] addr;
      logic        compat;
      logic [7:0]  strength;
      logic [31:0] last_seen;
      logic [23:0] payload;   // battery, capabilities, board
   } apt_entry_type;

   // cursor request
   typedef struct packed {
      logic              start;
      logic              move;
      logic signed [4:0] step;
   } apt_cur_ctl_type;

endpackage

`default_nettype wire

[rtl/apt_if.sv]
// ----------------------------------------------------------------------------
// apt channel interfaces
// Request, response and register write channels of the peer table.
// ----------------------------------------------------------------------------
`default_nettype none

interface apt_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command;
   logic [31:0] now_ms;
   logic [47:0] peer_address;
   logic        is_compatible;
   logic [7:0]  signal_strength;
   logic [7:0]  board_kind;
   logic [7:0]  capability_bits;
   logic [7:0]  battery_level;
   logic [4:0]  step;
   logic [2:0]  visible_position;

   modport source (output valid, command, now_ms, peer_address, is_compatible,
                   signal_strength, board_kind, capability_bits, battery_level,
                   step, visible_position, input ready);
   modport sink (input valid, command, now_ms, peer_address, is_compatible,
                 signal_strength, board_kind, capability_bits, battery_level,
                 step, visible_position, output ready);
endinterface

interface apt_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [47:0] entry_address;
   logic        entry_compatible;
   logic [7:0]  entry_strength;
   logic [7:0]  entry_board_kind;
   logic [7:0]  entry_capabilities;
   logic [7:0]  entry_battery;
   logic [2:0]  highlight_position;
   logic        has_selection;
   logic        selection_lost;
   logic [3:0]  alive_count;
   logic        any_compatible;

   modport source (output valid, found, entry_address, entry_compatible,
                   entry_strength, entry_board_kind, entry_capabilities,
                   entry_battery, highlight_position, has_selection,
                   selection_lost, alive_count, any_compatible, input ready);
   modport sink (input valid, found, entry_address, entry_compatible,
                 entry_strength, entry_board_kind, entry_capabilities,
                 entry_battery, highlight_position, has_selection,
                 selection_lost, alive_count, any_compatible, output ready);
endinterface

interface apt_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/apt_ram.sv]
// ----------------------------------------------------------------------------
// apt_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_ram #(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire [IDX_W-1:0]       wr_idx,
   input  apt_pkg::apt_entry_type wr_data,
   input  wire                   rd_en,
   input  wire [IDX_W-1:0]       rd_idx,
   output apt_pkg::apt_entry_type rd_data
);
   import apt_pkg::*;

   apt_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

[rtl/apt_cursor.sv]
// ----------------------------------------------------------------------------
// apt_cursor
// Highlight walker: places the highlight on a compatible alive entry (or at
// 0 if none), one slot per cycle over the alive and compatible flag vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_cursor #(
   parameter int SLOTS = 8,
   parameter int IDX_W = 3,
   parameter int CNT_W = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  apt_pkg::apt_cur_ctl_type ctl,
   input  wire [SLOTS-1:0]         alive_vec,
   input  wire [SLOTS-1:0]         compat_vec,
   input  wire [CNT_W-1:0]         count,
   input  wire                     any_compat,
   input  wire [IDX_W-1:0]         hl_in,
   output logic                    done,
   output logic [IDX_W-1:0]        hl_out
);
   import apt_pkg::*;

   localparam int SW = IDX_W + 6;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   typedef enum logic [1:0] {C_IDLE, C_LOCATE, C_CHECK, C_WALK} cur_state_type;

   cur_state_type     state_ff;
   logic [IDX_W-1:0]  j_ff, p_ff, seen_ff;
   logic              neg_ff, wrap_ff;

   logic signed [SW-1:0] sum, cnt_s;
   logic [IDX_W-1:0]     cnt_m1, p_start, jn;
   logic                 wrap_ev, wrapn;

   // starting position
   always_comb begin
      cnt_m1 = IDX_W'(count - CNT_W'(1));
      sum    = $signed({6'b0, hl_in}) + $signed({{(SW-5){ctl.step[4]}}, ctl.step});
      cnt_s  = $signed({{(SW-CNT_W){1'b0}}, count});
      if (ctl.move) begin
         if (sum < 0) begin
            p_start = cnt_m1;
         end else if (sum >= cnt_s) begin
            p_start = '0;
         end else begin
            p_start = sum[IDX_W-1:0];
         end
      end else begin
         if ((IDX_W+1)'(hl_in) >= (IDX_W+1)'(count)) begin
            p_start = cnt_m1;
         end else begin
            p_start = hl_in;
         end
      end
   end

   // next slot in circular order
   always_comb begin
      if (neg_ff) begin
         wrap_ev = (j_ff == '0);
         jn      = wrap_ev ? LAST : j_ff - IDX_W'(1);
      end else begin
         wrap_ev = (j_ff == LAST);
         jn      = wrap_ev ? '0 : j_ff + IDX_W'(1);
      end
      wrapn = wrap_ff | wrap_ev;
   end

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         state_ff <= C_IDLE;
         hl_out   <= '0;
      end else begin
         case (state_ff)
            C_IDLE: begin
               if (ctl.start) begin
                  if (count == '0 || !any_compat) begin
                     hl_out <= '0;
                     done   <= 1'b1;
                  end else begin
                     p_ff     <= p_start;
                     neg_ff   <= ctl.move && ctl.step[4];
                     j_ff     <= '0;
                     seen_ff  <= '0;
                     wrap_ff  <= 1'b0;
                     state_ff <= C_LOCATE;
                  end
               end
            end
            // find the slot at position p
            C_LOCATE: begin
               if (alive_vec[j_ff]) begin
                  if (seen_ff == p_ff) begin
                     state_ff <= C_CHECK;
                  end else begin
                     seen_ff <= seen_ff + IDX_W'(1);
                     j_ff    <= j_ff + IDX_W'(1);
                  end
               end else begin
                  j_ff <= j_ff + IDX_W'(1);
               end
            end
            C_CHECK: begin
               if (compat_vec[j_ff]) begin
                  hl_out   <= p_ff;
                  done     <= 1'b1;
                  state_ff <= C_IDLE;
               end else begin
                  state_ff <= C_WALK;
               end
            end
            // step to the next alive slot
            C_WALK: begin
               j_ff <= jn;
               if (alive_vec[jn]) begin
                  wrap_ff <= 1'b0;
                  if (neg_ff) begin
                     p_ff <= wrapn ? cnt_m1 : p_ff - IDX_W'(1);
                  end else begin
                     p_ff <= wrapn ? '0 : p_ff + IDX_W'(1);
                  end
                  state_ff <= C_CHECK;
               end else begin
                  wrap_ff <= wrapn;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/aging_peer_table_with_cursor.sv]
// ----------------------------------------------------------------------------
// aging_peer_table_with_cursor
// Peer table with aging, stalest-entry replacement, highlight and selection.
// ----------------------------------------------------------------------------
// One transaction at a time. Every command reads the whole entry memory once
// after any update; learn of an address other than the local one, touch and
// expire read it once more before, and in the S_WRITE state between the two
// scans learn writes its entry and touch a matching one. Such a learn, expire
// and move then walk the highlight over the alive flags, one slot per cycle;
// the memory's single read port sets the scan length. The response register
// lets the next request be taken while a response waits. Reset empties the
// table at once through per-slot used flags; no clearing pass is needed.
`default_nettype none

module aging_peer_table_with_cursor #(
   parameter int TABLE_SLOTS = 8
) (
   input wire     clock,
   input wire     reset,
   apt_req_if.sink   req_ch,
   apt_rsp_if.source rsp_ch,
   apt_csr_if.sink   csr_ch
);
   import apt_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCANA, S_WRITE, S_SCANB, S_CURS_GO, S_CURS_WAIT, S_DONE
   } state_type;

   state_type state_ff;

   // registers
   logic [47:0] loc_addr_ff;
   logic [31:0] timeout_ff;

   // latched request
   logic [3:0]  cmd_ff;
   logic [31:0] now_ff;
   logic [47:0] peer_ff;
   logic        cin_ff;
   logic [7:0]  str_ff, board_ff, cap_ff, bat_ff;
   logic [4:0]  step_ff;
   logic [2:0]  vpos_ff;
   logic        apply_ff;   // learn that is not the local address

   // table state outside the memory
   logic [TABLE_SLOTS-1:0] used_ff;
   logic [IDX_W-1:0]       hl_ff;
   logic                   sel_vld_ff;
   logic [47:0]            sel_addr_ff;

   // scan control
   logic [CNT_W-1:0] rd_cnt_ff;
   logic             d_vld_ff;
   logic [IDX_W-1:0] d_idx_ff;

   // first scan results
   logic             mhit_ff, fhit_ff;
   logic [IDX_W-1:0] midx_ff, vidx_ff;
   apt_entry_type    mword_ff;
   logic [7:0]       vstr_ff;
   logic [31:0]      best_ff;

   // second scan results
   logic [TABLE_SLOTS-1:0] alive_vec_ff, compat_vec_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   anyc_ff, selok_ff, fnd_ff, shit_ff;
   apt_entry_type          fword_ff;
   logic [47:0]            saddr_ff;

   // response register
   logic        rsp_vld_ff, rfound_ff, rcompat_ff, rhas_ff, rlost_ff, rany_ff;
   logic [47:0] raddr_ff;
   logic [7:0]  rstr_ff, rboard_ff, rcap_ff, rbat_ff;
   logic [2:0]  rhl_ff;
   logic [3:0]  rcnt_ff;

   // memory ports
   logic             wr_en, rd_en, scanning, last_d, ua, str_ok;
   logic [IDX_W-1:0] wr_idx;
   apt_entry_type    wr_data, rdata, rword;

   apt_cur_ctl_type  cur_ctl;
   logic             cur_done;
   logic [IDX_W-1:0] cur_hl;
   logic [IDX_W+2:0] hl_wide;
   logic [CNT_W+3:0] cnt_wide;

   logic req_acc, rsp_free;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_vld_ff || rsp_ch.ready;

   // read issue and returned word
   assign scanning = (state_ff == S_SCANA) || (state_ff == S_SCANB);
   assign rd_en    = scanning && (rd_cnt_ff < CNT_W'(TABLE_SLOTS));
   assign last_d   = d_vld_ff && (d_idx_ff == LAST);
   assign rword    = used_ff[d_idx_ff] ? rdata : '0;
   assign ua       = used_ff[d_idx_ff] && ((now_ff - rword.last_seen) <= timeout_ff);
   assign str_ok   = $signed(str_ff) > STRENGTH_FLOOR;

   // write port: expire during the first scan, learn and touch after it
   always_comb begin
      wr_en          = 1'b0;
      wr_idx         = d_idx_ff;
      wr_data        = rword;
      wr_data.compat = 1'b0;
      if (state_ff == S_SCANA && d_vld_ff && cmd_ff == CMD_EXPIRE
          && used_ff[d_idx_ff] && !ua) begin
         wr_en = 1'b1;
      end else if (state_ff == S_WRITE) begin
         if (cmd_ff == CMD_LEARN) begin
            wr_en             = 1'b1;
            wr_idx            = mhit_ff ? midx_ff : vidx_ff;
            wr_data.addr      = peer_ff;
            wr_data.compat    = cin_ff;
            wr_data.strength  = str_ok ? str_ff : (mhit_ff ? mword_ff.strength : vstr_ff);
            wr_data.last_seen = now_ff;
            wr_data.payload   = {bat_ff, cap_ff, board_ff};
         end else begin
            wr_en             = mhit_ff;
            wr_idx            = midx_ff;
            wr_data           = mword_ff;
            wr_data.last_seen = now_ff;
            wr_data.strength  = str_ok ? str_ff : mword_ff.strength;
         end
      end
   end

   apt_ram #(.DEPTH(TABLE_SLOTS), .IDX_W(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rdata)
   );

   assign cur_ctl.start = (state_ff == S_CURS_GO);
   assign cur_ctl.move  = (cmd_ff == CMD_MOVE);
   assign cur_ctl.step  = $signed(step_ff);

   apt_cursor #(.SLOTS(TABLE_SLOTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .ctl        (cur_ctl),
      .alive_vec  (alive_vec_ff),
      .compat_vec (compat_vec_ff),
      .count      (cnt_ff),
      .any_compat (anyc_ff),
      .hl_in      (hl_ff),
      .done       (cur_done),
      .hl_out     (cur_hl)
   );

   assign hl_wide  = {3'b0, hl_ff};
   assign cnt_wide = {4'b0, cnt_ff};

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         loc_addr_ff <= '0;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_LOCAL:   loc_addr_ff <= csr_ch.data;
            REG_TIMEOUT: timeout_ff  <= csr_ch.data[31:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath
   always_ff @(posedge clock) begin
      d_vld_ff <= rd_en;
      d_idx_ff <= rd_cnt_ff[IDX_W-1:0];
      if (rd_en) begin
         rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
      end
      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (reset) begin
         state_ff    <= S_IDLE;
         used_ff     <= '0;
         hl_ff       <= '0;
         sel_vld_ff  <= 1'b0;
         sel_addr_ff <= '0;
         rsp_vld_ff  <= 1'b0;
         d_vld_ff    <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  cmd_ff    <= req_ch.command;
                  now_ff    <= req_ch.now_ms;
                  peer_ff   <= req_ch.peer_address;
                  cin_ff    <= req_ch.is_compatible;
                  str_ff    <= req_ch.signal_strength;
                  board_ff  <= req_ch.board_kind;
                  cap_ff    <= req_ch.capability_bits;
                  bat_ff    <= req_ch.battery_level;
                  step_ff   <= req_ch.step;
                  vpos_ff   <= req_ch.visible_position;
                  apply_ff  <= (req_ch.command == CMD_LEARN)
                               && (req_ch.peer_address != loc_addr_ff);
                  rd_cnt_ff <= '0;
                  mhit_ff   <= 1'b0;
                  fhit_ff   <= 1'b0;
                  vidx_ff   <= '0;
                  best_ff   <= '1;
                  if ((req_ch.command == CMD_LEARN && req_ch.peer_address != loc_addr_ff)
                      || req_ch.command == CMD_TOUCH || req_ch.command == CMD_EXPIRE) begin
                     state_ff <= S_SCANA;
                  end else begin
                     cnt_ff   <= '0;
                     anyc_ff  <= 1'b0;
                     selok_ff <= 1'b0;
                     fnd_ff   <= 1'b0;
                     shit_ff  <= 1'b0;
                     state_ff <= S_SCANB;
                  end
               end
            end
            // address match and replacement choice
            S_SCANA: begin
               if (d_vld_ff) begin
                  if (!mhit_ff && used_ff[d_idx_ff] && rword.addr == peer_ff) begin
                     mhit_ff  <= 1'b1;
                     midx_ff  <= d_idx_ff;
                     mword_ff <= rword;
                  end
                  if (!fhit_ff) begin
                     if (!ua) begin
                        fhit_ff <= 1'b1;
                        vidx_ff <= d_idx_ff;
                        vstr_ff <= rword.strength;
                     end else if (d_idx_ff == '0 || rword.last_seen < best_ff) begin
                        best_ff <= rword.last_seen;
                        vidx_ff <= d_idx_ff;
                        vstr_ff <= rword.strength;
                     end
                  end
               end
               if (last_d) begin
                  if (cmd_ff == CMD_EXPIRE) begin
                     rd_cnt_ff <= '0;
                     cnt_ff    <= '0;
                     anyc_ff   <= 1'b0;
                     selok_ff  <= 1'b0;
                     fnd_ff    <= 1'b0;
                     shit_ff   <= 1'b0;
                     state_ff  <= S_SCANB;
                  end else begin
                     state_ff <= S_WRITE;
                  end
               end
            end
            S_WRITE: begin
               if (cmd_ff == CMD_LEARN) begin
                  used_ff[wr_idx] <= 1'b1;
               end
               rd_cnt_ff <= '0;
               cnt_ff    <= '0;
               anyc_ff   <= 1'b0;
               selok_ff  <= 1'b0;
               fnd_ff    <= 1'b0;
               shit_ff   <= 1'b0;
               state_ff  <= S_SCANB;
            end
            // status, flag vectors and read capture on the updated table
            S_SCANB: begin
               if (d_vld_ff) begin
                  alive_vec_ff[d_idx_ff]  <= ua;
                  compat_vec_ff[d_idx_ff] <= rword.compat;
                  if (ua) begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                  end
                  if (ua && rword.compat) begin
                     anyc_ff <= 1'b1;
                     if (rword.addr == sel_addr_ff) begin
                        selok_ff <= 1'b1;
                     end
                  end
                  if (!fnd_ff) begin
                     case (cmd_ff)
                        CMD_LOOKUP: begin
                           if (ua && rword.addr == peer_ff) begin
                              fnd_ff   <= 1'b1;
                              fword_ff <= rword;
                           end
                        end
                        CMD_READ_SEL: begin
                           if (sel_vld_ff && ua && rword.compat
                               && rword.addr == sel_addr_ff) begin
                              fnd_ff   <= 1'b1;
                              fword_ff <= rword;
                           end
                        end
                        CMD_READ_VIS: begin
                           if (ua && cnt_wide[CNT_W+2:0] == (CNT_W+3)'(vpos_ff)) begin
                              fnd_ff   <= 1'b1;
                              fword_ff <= rword;
                           end
                        end
                        CMD_SELECT: begin
                           if (ua && (IDX_W+3)'(cnt_ff) == hl_wide) begin
                              shit_ff  <= rword.compat;
                              saddr_ff <= rword.addr;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               if (last_d) begin
                  if (apply_ff || cmd_ff == CMD_EXPIRE || cmd_ff == CMD_MOVE) begin
                     state_ff <= S_CURS_GO;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_CURS_GO: begin
               state_ff <= S_CURS_WAIT;
            end
            S_CURS_WAIT: begin
               if (cur_done) begin
                  hl_ff    <= cur_hl;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_vld_ff <= 1'b1;
                  rfound_ff  <= fnd_ff;
                  raddr_ff   <= fnd_ff ? fword_ff.addr : '0;
                  rcompat_ff <= fnd_ff && fword_ff.compat;
                  rstr_ff    <= fnd_ff ? fword_ff.strength : '0;
                  rboard_ff  <= fnd_ff ? fword_ff.payload[7:0] : '0;
                  rcap_ff    <= fnd_ff ? fword_ff.payload[15:8] : '0;
                  rbat_ff    <= fnd_ff ? fword_ff.payload[23:16] : '0;
                  rhl_ff     <= hl_wide[2:0];
                  rcnt_ff    <= cnt_wide[3:0];
                  rany_ff    <= anyc_ff;
                  if (cmd_ff == CMD_SELECT) begin
                     sel_vld_ff  <= shit_ff;
                     sel_addr_ff <= shit_ff ? saddr_ff : '0;
                     rhas_ff     <= shit_ff;
                     rlost_ff    <= 1'b0;
                  end else if (cmd_ff == CMD_CLEAR) begin
                     sel_vld_ff  <= 1'b0;
                     sel_addr_ff <= '0;
                     rhas_ff     <= 1'b0;
                     rlost_ff    <= 1'b0;
                  end else begin
                     rhas_ff  <= sel_vld_ff;
                     rlost_ff <= sel_vld_ff && !selok_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid              = rsp_vld_ff;
   assign rsp_ch.found              = rfound_ff;
   assign rsp_ch.entry_address      = raddr_ff;
   assign rsp_ch.entry_compatible   = rcompat_ff;
   assign rsp_ch.entry_strength     = rstr_ff;
   assign rsp_ch.entry_board_kind   = rboard_ff;
   assign rsp_ch.entry_capabilities = rcap_ff;
   assign rsp_ch.entry_battery      = rbat_ff;
   assign rsp_ch.highlight_position = rhl_ff;
   assign rsp_ch.has_selection      = rhas_ff;
   assign rsp_ch.selection_lost     = rlost_ff;
   assign rsp_ch.alive_count        = rcnt_ff;
   assign rsp_ch.any_compatible     = rany_ff;

   // a taken request always starts work
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != S_IDLE)
      else $error("sequencer idle after request");

   // table writes only in the update phases
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SCANA || state_ff == S_WRITE))
      else $error("memory write outside update phase");

   // highlight lands inside the alive range
   a_hl_range: assert property (@(posedge clock) disable iff (reset)
      (cur_done && cnt_ff != '0) |-> ((IDX_W+1)'(cur_hl) < (IDX_W+1)'(cnt_ff)))
      else $error("highlight beyond alive count");

   // a response is only loaded when the register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_vld_ff && !rsp_ch.ready) |=> state_ff == S_DONE)
      else $error("response overwritten");

endmodule

`default_nettype wire
